/* hw/rtl/twap_pkg.sv */
// Shared constants and types for the TWAP order slicer.
`timescale 1ns / 1ps

package twap_pkg;

    // Default widths of the quantity and time fields.
    localparam int QTY_BITS_DEF  = 31;
    localparam int TIME_BITS_DEF = 63;

    // Duration in seconds and the nanosecond scale.
    localparam int DUR_BITS  = 25;
    localparam int NS_BITS   = 30;
    localparam int SPAN_BITS = DUR_BITS + NS_BITS;

    localparam logic [NS_BITS-1:0]  NS_PER_SEC     = 30'd1000000000;
    localparam logic [DUR_BITS-1:0] DUR_RESET      = 25'd60;
    localparam logic [63:0]         INTERVAL_RESET = 64'd5000000000;

    // Configuration register indexes.
    localparam int CFG_ADDR_BITS = 2;
    typedef logic [CFG_ADDR_BITS-1:0] cfg_addr_t;

    localparam cfg_addr_t CFG_START_TIME = 2'd0;
    localparam cfg_addr_t CFG_DURATION   = 2'd1;
    localparam cfg_addr_t CFG_TOTAL_QTY  = 2'd2;
    localparam cfg_addr_t CFG_INTERVAL   = 2'd3;

endpackage

/* hw/rtl/twap_order_slicer.sv */
// Top level of the TWAP order slicer: config registers, sequencer and output stage.
// A tick is accepted only in idle. After done the result is issued with nothing in it; otherwise
// the sequencer finds the elapsed time, checks it against the span and the interval, and for a
// slice target runs a shift, add and subtract divide, one add or subtract per cycle on one unit.
// Throughput: one tick at a time; the next is accepted once the result enters the output register.
// Reset: aresetn is synchronous, active low; restores duration 60 s, interval 5e9 ns and clears done.
`timescale 1ns / 1ps

module twap_order_slicer #(
    parameter int QTY_BITS  = twap_pkg::QTY_BITS_DEF,
    parameter int TIME_BITS = twap_pkg::TIME_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [twap_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [TIME_BITS-1:0]             cfg_wdata,

    // Tick input. s_tdata: [TIME_BITS-1:0] now_time, zero padded to whole bytes.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [((TIME_BITS+7)/8)*8-1:0]   s_tdata,

    // Result output. m_tdata: [0] slice_valid, [QTY_BITS:1] slice_quantity,
    // [QTY_BITS+1] done_res, zero padded to whole bytes.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [((QTY_BITS+2+7)/8)*8-1:0]  m_tdata
);
    import twap_pkg::*;

    localparam int IN_W   = ((TIME_BITS + 7) / 8) * 8;
    localparam int OUT_W  = ((QTY_BITS + 2 + 7) / 8) * 8;
    localparam int RW     = SPAN_BITS + 1;                          // divide remainder
    localparam int UW     = (TIME_BITS > RW) ? TIME_BITS : RW;      // shared unit width
    localparam int BIT_W  = $clog2(QTY_BITS);

    // One-hot sequencer states.
    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_ELAP  = 10'b00_0000_0010,
        S_SPAN  = 10'b00_0000_0100,
        S_GAP   = 10'b00_0000_1000,
        S_INTV  = 10'b00_0001_0000,
        S_SHIFT = 10'b00_0010_0000,
        S_ADD   = 10'b00_0100_0000,
        S_SUB   = 10'b00_1000_0000,
        S_DIFF  = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TIME_BITS-1:0] start_reg;
    logic [DUR_BITS-1:0]  dur_reg;
    logic [QTY_BITS-1:0]  total_reg;
    logic [TIME_BITS-1:0] intv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            dur_reg   <= DUR_RESET;
            total_reg <= '0;
            intv_reg  <= TIME_BITS'(INTERVAL_RESET);
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_START_TIME: start_reg <= cfg_wdata;
                CFG_DURATION:   dur_reg   <= DUR_BITS'(cfg_wdata);
                CFG_TOTAL_QTY:  total_reg <= QTY_BITS'(cfg_wdata);
                CFG_INTERVAL:   intv_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Schedule length in ns, refreshed every cycle from the duration register.
    logic [SPAN_BITS-1:0] span;

    twap_span_mul u_span_mul (
        .aclk   (aclk),
        .dur_i  (dur_reg),
        .span_o (span)
    );

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    state_t               state_reg,   state_next;
    logic                 finished_reg, finished_next;
    logic                 final_reg,   final_next;      // completing tick
    logic [QTY_BITS-1:0]  filled_reg,  filled_next;
    logic [TIME_BITS-1:0] last_reg,    last_next;
    logic [TIME_BITS-1:0] now_reg,     now_next;
    logic [TIME_BITS-1:0] elap_reg,    elap_next;
    logic [TIME_BITS-1:0] gap_reg,     gap_next;
    logic [RW-1:0]        r_reg,       r_next;
    logic [QTY_BITS-1:0]  q_reg,       q_next;
    logic [BIT_W-1:0]     bit_reg,     bit_next;
    logic                 rv_reg,      rv_next;          // pending result fields
    logic [QTY_BITS-1:0]  rq_reg,      rq_next;
    logic                 rd_reg,      rd_next;
    logic                 mv_reg,      mv_next;          // output register
    logic                 ov_reg,      ov_next;
    logic [QTY_BITS-1:0]  oq_reg,      oq_next;
    logic                 od_reg,      od_next;

    // Shared unit operands.
    logic [UW-1:0] op_a, op_b, alu_res;
    logic          op_sub, alu_neg, alu_zero;

    twap_addsub #(.W(UW)) u_addsub (
        .a_i   (op_a),
        .b_i   (op_b),
        .sub_i (op_sub),
        .res_o (alu_res),
        .neg_o (alu_neg)
    );

    assign alu_zero = (alu_res == '0);

    // Route the operands of the current step into the unit.
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_sub = 1'b1;
        case (state_reg)
            S_ELAP: begin
                op_a = UW'(now_reg);
                op_b = UW'(start_reg);
            end
            S_SPAN: begin
                op_a = UW'(elap_reg);
                op_b = UW'(span);
            end
            S_GAP: begin
                op_a = UW'(now_reg);
                op_b = UW'(last_reg);
            end
            S_INTV: begin
                op_a = UW'(intv_reg);
                op_b = UW'(gap_reg);
            end
            S_SHIFT: begin
                op_a = UW'({r_reg, 1'b0});
                op_b = UW'(span);
            end
            S_ADD: begin
                op_a   = UW'(r_reg);
                op_b   = UW'(elap_reg);
                op_sub = 1'b0;
            end
            S_SUB: begin
                op_a = UW'(r_reg);
                op_b = UW'(span);
            end
            S_DIFF: begin
                op_a = UW'(q_reg);
                op_b = UW'(filled_reg);
            end
            default: ;
        endcase
    end

    logic out_free;
    assign out_free = !mv_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        finished_next = finished_reg;
        final_next    = final_reg;
        filled_next   = filled_reg;
        last_next     = last_reg;
        now_next      = now_reg;
        elap_next     = elap_reg;
        gap_next      = gap_reg;
        r_next        = r_reg;
        q_next        = q_reg;
        bit_next      = bit_reg;
        rv_next       = rv_reg;
        rq_next       = rq_reg;
        rd_next       = rd_reg;
        mv_next       = mv_reg;
        ov_next       = ov_reg;
        oq_next       = oq_reg;
        od_next       = od_reg;

        // Drop the output item once taken.
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    now_next   = s_tdata[TIME_BITS-1:0];
                    rv_next    = 1'b0;
                    rq_next    = '0;
                    rd_next    = finished_reg;
                    final_next = 1'b0;
                    // After done, answer at once with nothing issued.
                    state_next = finished_reg ? S_OUT : S_ELAP;
                end
            end
            S_ELAP: begin
                // Tick before start: nothing issued, state kept.
                elap_next  = TIME_BITS'(alu_res);
                state_next = alu_neg ? S_OUT : S_SPAN;
            end
            S_SPAN: begin
                if (!alu_neg) begin
                    // Schedule complete: issue the remainder against total.
                    finished_next = 1'b1;
                    final_next    = 1'b1;
                    rd_next       = 1'b1;
                    q_next        = total_reg;
                    state_next    = S_DIFF;
                end else if (last_reg == '0) begin
                    r_next     = '0;
                    q_next     = '0;
                    bit_next   = BIT_W'(QTY_BITS - 1);
                    state_next = S_SHIFT;
                end else begin
                    state_next = S_GAP;
                end
            end
            S_GAP: begin
                // Time not past the last slice: interval has not passed.
                gap_next   = TIME_BITS'(alu_res);
                state_next = (alu_neg || alu_zero) ? S_OUT : S_INTV;
            end
            S_INTV: begin
                // Interval minus gap borrows when the gap is strictly larger.
                if (alu_neg) begin
                    r_next     = '0;
                    q_next     = '0;
                    bit_next   = BIT_W'(QTY_BITS - 1);
                    state_next = S_SHIFT;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_SHIFT: begin
                if (!alu_neg) begin
                    r_next = RW'(alu_res);
                    q_next = {q_reg[QTY_BITS-2:0], 1'b1};
                end else begin
                    r_next = {r_reg[RW-2:0], 1'b0};
                    q_next = {q_reg[QTY_BITS-2:0], 1'b0};
                end
                if (total_reg[bit_reg]) begin
                    state_next = S_ADD;
                end else if (bit_reg == '0) begin
                    state_next = S_DIFF;
                end else begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_ADD: begin
                r_next     = RW'(alu_res);
                state_next = S_SUB;
            end
            S_SUB: begin
                if (!alu_neg) begin
                    r_next = RW'(alu_res);
                    q_next = q_reg + 1'b1;
                end
                if (bit_reg == '0) begin
                    state_next = S_DIFF;
                end else begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_DIFF: begin
                // Issue only the positive excess over the filled amount.
                if (!alu_neg && !alu_zero) begin
                    rv_next     = 1'b1;
                    rq_next     = QTY_BITS'(alu_res);
                    filled_next = q_reg;
                    if (!final_reg) begin
                        last_next = now_reg;
                    end
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                // Hold the result until the output register is free.
                if (out_free) begin
                    mv_next    = 1'b1;
                    ov_next    = rv_reg;
                    oq_next    = rq_reg;
                    od_next    = rd_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            finished_reg <= 1'b0;
            filled_reg   <= '0;
            last_reg     <= '0;
            mv_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            finished_reg <= finished_next;
            filled_reg   <= filled_next;
            last_reg     <= last_next;
            mv_reg       <= mv_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge aclk) begin
        final_reg <= final_next;
        now_reg   <= now_next;
        elap_reg  <= elap_next;
        gap_reg   <= gap_next;
        r_reg     <= r_next;
        q_reg     <= q_next;
        bit_reg   <= bit_next;
        rv_reg    <= rv_next;
        rq_reg    <= rq_next;
        rd_reg    <= rd_next;
        ov_reg    <= ov_next;
        oq_reg    <= oq_next;
        od_reg    <= od_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = OUT_W'({od_reg, oq_reg, ov_reg});

    // Input padding bits above now_time are ignored.
    logic unused_pad;
    assign unused_pad = ^s_tdata;

endmodule

/* hw/rtl/twap_addsub.sv */
// Shared add/subtract unit with borrow flag, used by every arithmetic step of the sequencer.
`timescale 1ns / 1ps

module twap_addsub #(
    parameter int W = 64
) (
    input  logic [W-1:0] a_i,
    input  logic [W-1:0] b_i,
    input  logic         sub_i,
    output logic [W-1:0] res_o,
    output logic         neg_o
);
    logic [W:0] sum;

    // a + ~b + 1 when subtracting; a missing carry out marks a borrow.
    assign sum   = {1'b0, a_i} + {1'b0, b_i ^ {W{sub_i}}} + {{W{1'b0}}, sub_i};
    assign res_o = sum[W-1:0];
    assign neg_o = sub_i & ~sum[W];

endmodule

/* hw/rtl/twap_span_mul.sv */
// Registered conversion of the schedule duration from seconds to nanoseconds.
`timescale 1ns / 1ps

module twap_span_mul (
    input  logic                          aclk,
    input  logic [twap_pkg::DUR_BITS-1:0]  dur_i,
    output logic [twap_pkg::SPAN_BITS-1:0] span_o
);
    import twap_pkg::*;

    logic [SPAN_BITS-1:0] span_reg;
    logic [SPAN_BITS-1:0] span_next;

    // 25 x 30 bit constant product, exact in 55 bits.
    assign span_next = SPAN_BITS'(dur_i) * SPAN_BITS'(NS_PER_SEC);

    always_ff @(posedge aclk) begin
        span_reg <= span_next;
    end

    assign span_o = span_reg;

endmodule

/* hw/rtl/twap_checker.sv */
// Port-level checker for the TWAP order slicer, bound to the top level.
`timescale 1ns / 1ps

module twap_checker #(
    parameter int QTY_BITS = twap_pkg::QTY_BITS_DEF,
    parameter int OUT_W    = 40
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);
    logic done_seen_reg;

    // Track whether a done item has already left the block.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_seen_reg <= 1'b0;
        end else if (m_tvalid && m_tready && m_tdata[QTY_BITS+1]) begin
            done_seen_reg <= 1'b1;
        end
    end

    // Stalled output item stays valid.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    // One tick at a time: no acceptance right after an acceptance.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // No slice means zero quantity.
    a_zero_qty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[QTY_BITS:1] == '0)
        else $error("quantity without slice");

    // After done, every item keeps done and issues nothing.
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && done_seen_reg |-> m_tdata[QTY_BITS+1] && !m_tdata[0])
        else $error("activity after done");

endmodule

bind twap_order_slicer twap_checker #(
    .QTY_BITS (QTY_BITS),
    .OUT_W    (((QTY_BITS + 2 + 7) / 8) * 8)
) u_twap_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* test/twap_order_slicer_checker.sv */
// Checker for the TWAP order slicer: tracks config writes, predicts each slice, compares results.
`timescale 1ns / 1ps

module twap_order_slicer_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  twap_pkg::cfg_addr_t       cfg_addr,
    input  logic [62:0]               cfg_wdata,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [63:0]               s_tdata,   // [62:0] now_time
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [39:0]               m_tdata,   // [0] slice_valid, [31:1] slice_quantity,
                                                 // [32] done_res
    output int                        errors,
    output int                        pending
);
    import twap_pkg::*;

    // Same layout as m_tdata[32:0]: slice_valid in the lowest bit.
    typedef struct packed {
        logic        done;
        logic [30:0] qty;
        logic        valid;
    } slice_result_t;

    // Shadow of the schedule registers.
    logic [62:0] start_ns;
    logic [24:0] dur_s;
    logic [30:0] parent_qty;
    logic [62:0] interval_ns;

    // Shadow of the slicing state.
    logic [30:0] filled;
    logic [62:0] last_slice_ns;
    logic        finished;

    slice_result_t expected_slices[$];

    // Work out the child order for one tick and advance the schedule.
    function automatic slice_result_t advance_schedule(input logic [62:0] now);
        logic [63:0]   span;
        logic [62:0]   elapsed;
        logic [127:0]  product;
        logic [63:0]   target;
        logic          due;
        slice_result_t res;
        res = '0;
        span = 64'(dur_s) * 64'd1000000000;
        if (!finished && now >= start_ns) begin
            elapsed = now - start_ns;
            if (64'(elapsed) >= span) begin
                // schedule over: flush whatever is still unfilled
                if (parent_qty > filled) begin
                    res.valid = 1'b1;
                    res.qty   = parent_qty - filled;
                    filled    = parent_qty;
                end
                finished = 1'b1;
            end else begin
                // a zero last time stands for no slice yet
                due = (last_slice_ns == '0) ||
                      (now > last_slice_ns && (now - last_slice_ns) > interval_ns);
                if (due) begin
                    product = 128'(elapsed) * 128'(parent_qty);
                    target  = 64'(product / 128'(span));
                    if (target > 64'(filled)) begin
                        res.valid     = 1'b1;
                        res.qty       = 31'(target - 64'(filled));
                        filled        = 31'(target);
                        last_slice_ns = now;
                    end
                end
            end
        end
        res.done = finished;
        return res;
    endfunction

    always @(posedge aclk) begin
        slice_result_t want;
        slice_result_t got;
        int            bad;
        bad = 0;
        if (!aresetn) begin
            start_ns      = '0;
            dur_s         = DUR_RESET;
            parent_qty    = '0;
            interval_ns   = INTERVAL_RESET[62:0];
            filled        = '0;
            last_slice_ns = '0;
            finished      = 1'b0;
            expected_slices.delete();
            pending <= 0;
            errors  <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_START_TIME: start_ns    = cfg_wdata;
                    CFG_DURATION:   dur_s       = cfg_wdata[24:0];
                    CFG_TOTAL_QTY:  parent_qty  = cfg_wdata[30:0];
                    CFG_INTERVAL:   interval_ns = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[32:0];
                if (expected_slices.size() == 0) begin
                    $error("slice result with no tick waiting: %h", m_tdata);
                    bad++;
                end else begin
                    want = expected_slices.pop_front();
                    if (got.valid !== want.valid) begin
                        $error("slice_valid: expected %0d, got %0d", want.valid, got.valid);
                        bad++;
                    end
                    if (got.qty !== want.qty) begin
                        $error("slice_quantity: expected %0d, got %0d", want.qty, got.qty);
                        bad++;
                    end
                    if (got.done !== want.done) begin
                        $error("done_res: expected %0d, got %0d", want.done, got.done);
                        bad++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_slices.push_back(advance_schedule(s_tdata[62:0]));
            pending <= expected_slices.size();
            errors  <= errors + bad;
        end
    end

endmodule

/* test/twap_order_slicer_tb.sv */
// Testbench top for the TWAP order slicer: clock, reset, tick stimulus and verdict.
`timescale 1ns / 1ps

module twap_order_slicer_tb;
    import twap_pkg::*;

    localparam logic [62:0] TIME_MAX = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [24:0] DUR_MAX  = 25'h1FF_FFFF;
    localparam logic [30:0] QTY_MAX  = 31'h7FFF_FFFF;
    localparam logic [63:0] NS_PER_S = 64'd1000000000;
    // Alternating bit patterns used as schedule starts in the directed part.
    localparam logic [62:0] PAT_A    = 63'h0555_5555_5555_5555;
    localparam logic [62:0] PAT_B    = 63'h0AAA_AAAA_AAAA_AAAA;
    localparam int          PHASES   = 21;
    localparam int          PER_PHASE = 45;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    cfg_addr_t   cfg_addr  = CFG_START_TIME;
    logic [62:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;   // [62:0] now_time
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // [0] slice_valid, [31:1] slice_quantity, [32] done_res

    // Set while both sides must run without idling.
    logic        calm      = 1'b0;

    int          errors;
    int          pending;
    int          wait_cycles;

    // Schedule of the phase being built.
    logic [62:0] start_ns;
    logic [62:0] interval_ns;
    logic [62:0] horizon;
    logic [63:0] span_ns;
    logic [24:0] dur_s;
    logic [30:0] parent_qty;
    logic [31:0] band_lo;

    twap_order_slicer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    twap_order_slicer_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .errors    (errors),
        .pending   (pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Result side: stall with a chance of 29 in a hundred, never while calm.
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 29);
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20000000;
        $display("twap_order_slicer_tb: FAIL");
        $finish;
    end

    // Uniform-ish 64-bit value below lim; lim must be nonzero.
    function automatic logic [63:0] rand_below(input logic [63:0] lim);
        return {$urandom, $urandom} % lim;
    endfunction

    // Offer one tick, with a random gap in front of it, and hold it until taken.
    // tvalid stays high when the next tick follows right away.
    task automatic send_tick(input logic [62:0] now);
        if (!calm && $urandom_range(0, 99) < 29) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (!calm && $urandom_range(0, 99) < 29);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, now};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop tvalid and wait until every tick has its result back, then write all
    // four registers on back-to-back cycles.
    task automatic reprogram(input logic [62:0] start, input logic [24:0] dur,
                             input logic [30:0] total, input logic [62:0] interval);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_START_TIME;
        cfg_wdata <= start;
        @(posedge aclk);
        cfg_addr  <= CFG_DURATION;
        cfg_wdata <= 63'(dur);
        @(posedge aclk);
        cfg_addr  <= CFG_TOTAL_QTY;
        cfg_wdata <= 63'(total);
        @(posedge aclk);
        cfg_addr  <= CFG_INTERVAL;
        cfg_wdata <= interval;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // One schedule phase: ticks mostly walk forward through the window, stopping
    // short of its end so the schedule never completes; some land before the start
    // and some step back in time.
    task automatic run_phase(input logic [62:0] start, input logic [24:0] dur,
                             input logic [30:0] total, input logic [62:0] interval,
                             input int n);
        logic [63:0] span;
        logic [63:0] step;
        logic [63:0] cursor;
        logic [62:0] now;
        int          r;
        reprogram(start, dur, total, interval);
        span   = 64'(dur) * NS_PER_S;
        step   = span / 64'(n);
        cursor = '0;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8 && start != '0) begin
                now = start - 63'd1 -
                      63'(rand_below((64'(start) < (64'd1 << 40)) ? 64'(start) : (64'd1 << 40)));
            end else if (r < 14) begin
                now = start + 63'(rand_below(cursor + 64'd1));
            end else begin
                cursor = cursor + rand_below(2 * step + 64'd1);
                if (cursor >= span)
                    cursor = span - 64'd1;
                now = start + 63'(cursor);
            end
            send_tick(now);
        end
    endtask

    initial begin
        // Hold reset, then release it before sending any item.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: total is zero, so nothing can be issued.
        send_tick('0);
        send_tick(63'd2000000000);

        // Register extremes: tick at time zero lies before the start, tick at the
        // largest time sits exactly on the start.
        reprogram(TIME_MAX, DUR_MAX, QTY_MAX, '0);
        send_tick('0);
        send_tick(TIME_MAX);

        // One-second schedule, zero interval: first slice, same time again, a step
        // back, a 1 ns step whose target is not above the fill, a second slice and
        // a tick just before the start.
        reprogram(PAT_A, 25'd1, 31'd1000, '0);
        send_tick(PAT_A + 63'd250000000);
        send_tick(PAT_A + 63'd250000000);
        send_tick(PAT_A + 63'd100000000);
        send_tick(PAT_A + 63'd250000001);
        send_tick(PAT_A + 63'd500000000);
        send_tick(PAT_A - 63'd1);

        // Total lowered below the fill, then the largest interval blocks a slice.
        reprogram(PAT_B, 25'd2, 31'd100, TIME_MAX);
        send_tick(PAT_B + 63'd1900000000);
        reprogram(PAT_B, 25'd2, QTY_MAX, TIME_MAX);
        send_tick(PAT_B + 63'd1000000000);
        horizon = PAT_B + 63'd2000000000;

        // Random phases. Totals mostly climb one octave per phase so the fill rarely
        // catches up; starts mostly move past every earlier window.
        for (int k = 0; k < PHASES; k++) begin
            calm <= (k == 6 || k == 7);
            case ($urandom_range(0, 9))
                0:       dur_s = 25'd1;
                1:       dur_s = DUR_MAX;
                2, 3:    dur_s = 25'($urandom_range(1, 32'h1FF_FFFF));
                default: dur_s = 25'($urandom_range(1, 3600));
            endcase
            span_ns = 64'(dur_s) * NS_PER_S;
            if ($urandom_range(0, 7) == 0) begin
                // land back in time, before slices already recorded
                start_ns = 63'(rand_below(64'(horizon)));
            end else begin
                start_ns = horizon + 63'd1 + 63'(rand_below(64'd1 << 58));
            end
            if (64'(start_ns) + span_ns > 64'(horizon))
                horizon = 63'(64'(start_ns) + span_ns);
            band_lo = 32'd1 << (10 + k);
            if ($urandom_range(0, 7) == 0)
                parent_qty = 31'($urandom_range(0, band_lo));
            else
                parent_qty = 31'($urandom_range(band_lo, (band_lo << 1) - 32'd1));
            case ($urandom_range(0, 19))
                0, 1, 2: interval_ns = '0;
                3:       interval_ns = TIME_MAX;
                default: interval_ns = 63'(rand_below(2 * (span_ns / PER_PHASE) + 64'd1));
            endcase
            run_phase(start_ns, dur_s, parent_qty, interval_ns, PER_PHASE);
        end
        calm <= 1'b0;

        // Closing: a short ten-second window at full total, then the duration goes
        // to zero so the first tick at or after the start completes the schedule
        // and flushes the remainder; later ticks only repeat done.
        start_ns    = horizon + 63'd1 + 63'(rand_below(64'd1 << 40));
        interval_ns = 63'(rand_below(64'd2000000000));
        run_phase(start_ns, 25'd10, QTY_MAX, interval_ns, 6);
        reprogram(start_ns, '0, QTY_MAX, interval_ns);
        send_tick(start_ns - 63'd1);
        send_tick(start_ns + 63'(rand_below(64'd1 << 32)));
        send_tick(start_ns + 63'd5);
        send_tick(TIME_MAX);
        send_tick('0);

        // Drain, then leave room for any stray result before the verdict.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 5000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (120) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("twap_order_slicer_tb: PASS");
        else
            $display("twap_order_slicer_tb: FAIL");
        $finish;
    end

endmodule
